/* hdl/rlsd_pkg.sv */
// shared types, constants and codes for the rgb led strip shift driver
`default_nettype none

package rlsd_pkg;

	// buffer geometry
	localparam int MAX_LEDS    = 1024;
	localparam int BLANK_COUNT = 1000;
	localparam int FB_ADDR_W   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int PTR_MAX     = (MAX_LEDS > BLANK_COUNT) ? MAX_LEDS : BLANK_COUNT;
	localparam int LED_PTR_W   = $clog2(PTR_MAX + 1);

	// field widths
	localparam int ACTION_W   = 3;
	localparam int INDEX_W    = 10;
	localparam int CHAN_W     = 8;
	localparam int COLOR_W    = 3 * CHAN_W;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 11;
	localparam int PERIOD_W   = 32;
	localparam int LATCH_W    = 16;
	localparam int BIT_PTR_W  = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int BITS_PER_LED = COLOR_W;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_SET   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_FILL  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_SEND  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_BLANK = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BUSY  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMMIT_EN      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PERIOD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LATCH_TICKS    = 2'd3;

	// reset values of the registers
	localparam logic [COUNT_W-1:0] LED_COUNT_RST   = 11'd30;
	localparam logic [LATCH_W-1:0] LATCH_TICKS_RST = 16'd2000;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_FRAME,
		MODE_BLANK,
		MODE_LATCH
	} mode_t;

	typedef enum logic [1:0] {
		CTL_CLEAR,
		CTL_RUN,
		CTL_FILL
	} ctl_state_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  led_count;
		logic                commit_en;
		logic [PERIOD_W-1:0] refresh_period;
		logic [LATCH_W-1:0]  latch_ticks;
	} cfg_t;

	typedef struct packed {
		logic                 we;
		logic [FB_ADDR_W-1:0] waddr;
		logic [COLOR_W-1:0]   wdata;
		logic [FB_ADDR_W-1:0] raddr;
	} fb_req_t;

endpackage

`default_nettype wire

/* hdl/rlsd_if.sv */
// channel interfaces: input items, result items and configuration writes
`default_nettype none

interface rlsd_item_if;
	logic                              valid;
	logic                              ready;
	logic [rlsd_pkg::ACTION_W-1:0]     action;
	logic [rlsd_pkg::INDEX_W-1:0]      led_index;
	logic [rlsd_pkg::CHAN_W-1:0]       red;
	logic [rlsd_pkg::CHAN_W-1:0]       green;
	logic [rlsd_pkg::CHAN_W-1:0]       blue;
	logic                              end_of_batch;

	modport source (output valid, action, led_index, red, green, blue, end_of_batch,
		input ready);
	modport sink (input valid, action, led_index, red, green, blue, end_of_batch,
		output ready);
endinterface

interface rlsd_result_if;
	logic                              valid;
	logic                              ready;
	logic                              serial_clock;
	logic                              serial_data;
	logic                              busy_res;
	logic [rlsd_pkg::STATUS_W-1:0]     status;

	modport source (output valid, serial_clock, serial_data, busy_res, status,
		input ready);
	modport sink (input valid, serial_clock, serial_data, busy_res, status,
		output ready);
endinterface

interface rlsd_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rlsd_pkg::CFG_IDX_W-1:0]    reg_index;
	logic [rlsd_pkg::CFG_DATA_W-1:0]   wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

/* hdl/rlsd_frame_mem.sv */
// frame buffer memory, one write and one registered read port per cycle
`default_nettype none

module rlsd_frame_mem (
	input  wire logic                          clk,
	input  wire rlsd_pkg::fb_req_t             req,
	output logic [rlsd_pkg::COLOR_W-1:0]       rdata
);

	logic [rlsd_pkg::COLOR_W-1:0] mem [rlsd_pkg::MAX_LEDS];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// read port, new data wins on a same-address write
	always_ff @(posedge clk) begin
		if (req.we && (req.waddr == req.raddr)) begin
			rdata <= req.wdata;
		end else begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/rlsd_ctrl.sv */
// item handling, serial shifter, latch and refresh timers, fill and clear sweeps
`default_nettype none

module rlsd_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire rlsd_pkg::cfg_t           cfg,
	rlsd_item_if.sink                     item_in,
	rlsd_result_if.source                 result_out,
	output rlsd_pkg::fb_req_t             fb_req,
	input  wire logic [rlsd_pkg::COLOR_W-1:0] fb_rdata
);

	localparam int CW = rlsd_pkg::COLOR_W;
	localparam int PW = rlsd_pkg::LED_PTR_W;
	localparam int AW = rlsd_pkg::FB_ADDR_W;
	localparam int BW = rlsd_pkg::BIT_PTR_W;
	localparam int LW = rlsd_pkg::LATCH_W;
	localparam int RW = rlsd_pkg::PERIOD_W;
	localparam int NW = rlsd_pkg::COUNT_W;

	rlsd_pkg::ctl_state_t st_q, st_nxt;
	rlsd_pkg::mode_t      mode_q, mode_nxt;

	logic [PW-1:0] led_ptr_q, led_ptr_nxt;
	logic [BW-1:0] bit_ptr_q, bit_ptr_nxt;
	logic          half_q, half_nxt;
	logic [CW-1:0] shift_q, shift_nxt, shift_cur;
	logic [LW-1:0] latch_cnt_q, latch_cnt_nxt;
	logic [RW-1:0] refresh_cnt_q, refresh_cnt_nxt;
	logic          clk_line_q, clk_line_nxt;
	logic          data_line_q, data_line_nxt;
	logic          load_pend_q, rd_issue;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] fill_addr_q;
	logic [CW-1:0] fill_color_q;

	logic                              res_valid_q;
	logic                              res_clk_q, res_data_q, res_busy_q;
	logic [rlsd_pkg::STATUS_W-1:0]     res_status_q, status;

	logic          acc, busy, fill_go, fill_last, clear_last, res_load;
	logic          start_frame, start_blank, go_latch;
	logic          set_wr;
	logic [NW-1:0] act_cnt;
	logic [PW-1:0] led_ptr_inc;
	logic [CW-1:0] color_in;

	// effective count and small helpers
	assign act_cnt = (32'(cfg.led_count) > rlsd_pkg::MAX_LEDS) ?
		NW'(rlsd_pkg::MAX_LEDS) : cfg.led_count;
	assign color_in   = {item_in.red, item_in.green, item_in.blue};
	assign acc        = item_in.valid && item_in.ready;
	assign busy       = (mode_q != rlsd_pkg::MODE_IDLE);
	assign shift_cur  = load_pend_q ? fb_rdata : shift_q;
	assign fill_last  = (st_q == rlsd_pkg::CTL_FILL) &&
		((32'(fill_addr_q) + 32'd1) == 32'(act_cnt));
	assign clear_last = (st_q == rlsd_pkg::CTL_CLEAR) &&
		(fill_addr_q == AW'(rlsd_pkg::MAX_LEDS - 1));
	assign led_ptr_inc = led_ptr_q + PW'(1);

	// sequencer next state
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			rlsd_pkg::CTL_CLEAR: begin
				if (clear_last) st_nxt = rlsd_pkg::CTL_RUN;
			end
			rlsd_pkg::CTL_RUN: begin
				if (fill_go) st_nxt = rlsd_pkg::CTL_FILL;
			end
			rlsd_pkg::CTL_FILL: begin
				if (fill_last) st_nxt = rlsd_pkg::CTL_RUN;
			end
			default: st_nxt = rlsd_pkg::CTL_CLEAR;
		endcase
	end

	// sequencer outputs: handshake and buffer write port
	always_comb begin
		item_in.ready = (st_q == rlsd_pkg::CTL_RUN) && (!res_valid_q || result_out.ready);
		fb_req.we     = 1'b0;
		fb_req.waddr  = fill_addr_q;
		fb_req.wdata  = '0;
		fb_req.raddr  = rd_addr;
		unique case (st_q)
			rlsd_pkg::CTL_CLEAR: begin
				fb_req.we = 1'b1;
			end
			rlsd_pkg::CTL_FILL: begin
				fb_req.we    = 1'b1;
				fb_req.wdata = fill_color_q;
			end
			rlsd_pkg::CTL_RUN: begin
				if (set_wr) begin
					fb_req.we    = 1'b1;
					fb_req.waddr = AW'(item_in.led_index);
					fb_req.wdata = color_in;
				end
			end
			default: fb_req.we = 1'b0;
		endcase
	end

	// item decode and serial state update
	always_comb begin
		mode_nxt        = mode_q;
		led_ptr_nxt     = led_ptr_q;
		bit_ptr_nxt     = bit_ptr_q;
		half_nxt        = half_q;
		shift_nxt       = shift_cur;
		latch_cnt_nxt   = latch_cnt_q;
		refresh_cnt_nxt = refresh_cnt_q;
		clk_line_nxt    = clk_line_q;
		data_line_nxt   = data_line_q;
		status          = rlsd_pkg::STAT_OK;
		rd_issue        = 1'b0;
		rd_addr         = '0;
		set_wr          = 1'b0;
		fill_go         = 1'b0;
		start_frame     = 1'b0;
		start_blank     = 1'b0;
		go_latch        = 1'b0;

		if ((st_q == rlsd_pkg::CTL_RUN) && acc) begin
			unique case (item_in.action)
				rlsd_pkg::ACT_SET: begin
					if (busy) begin
						status = rlsd_pkg::STAT_BUSY;
					end else if (32'(item_in.led_index) >= 32'(act_cnt)) begin
						status = rlsd_pkg::STAT_RANGE;
					end else begin
						set_wr = 1'b1;
						if (cfg.commit_en && item_in.end_of_batch) start_frame = 1'b1;
					end
				end
				rlsd_pkg::ACT_FILL: begin
					if (busy) begin
						status = rlsd_pkg::STAT_BUSY;
					end else if (act_cnt == '0) begin
						if (cfg.commit_en) start_frame = 1'b1;
					end else begin
						fill_go = 1'b1;
					end
				end
				rlsd_pkg::ACT_SEND: begin
					if (busy) status = rlsd_pkg::STAT_BUSY;
					else start_frame = 1'b1;
				end
				rlsd_pkg::ACT_BLANK: begin
					if (busy) status = rlsd_pkg::STAT_BUSY;
					else start_blank = 1'b1;
				end
				rlsd_pkg::ACT_TICK: begin
					if (mode_q == rlsd_pkg::MODE_IDLE) begin
						// refresh timer runs on idle ticks only
						if (cfg.refresh_period != '0) begin
							if (refresh_cnt_q <= RW'(1)) begin
								refresh_cnt_nxt = '0;
								start_frame     = 1'b1;
							end else begin
								refresh_cnt_nxt = refresh_cnt_q - RW'(1);
							end
						end
					end else if (mode_q == rlsd_pkg::MODE_LATCH) begin
						clk_line_nxt  = 1'b0;
						latch_cnt_nxt = latch_cnt_q - LW'(1);
						if (latch_cnt_nxt == '0) begin
							mode_nxt        = rlsd_pkg::MODE_IDLE;
							refresh_cnt_nxt = cfg.refresh_period;
						end
					end else if (!half_q) begin
						// low half: present the top bit
						clk_line_nxt  = 1'b0;
						data_line_nxt = shift_cur[CW-1];
						half_nxt      = 1'b1;
					end else begin
						// high half: raise clock and advance
						clk_line_nxt = 1'b1;
						half_nxt     = 1'b0;
						shift_nxt    = {shift_cur[CW-2:0], 1'b0};
						bit_ptr_nxt  = bit_ptr_q + BW'(1);
						if (32'(bit_ptr_q) == rlsd_pkg::BITS_PER_LED - 1) begin
							bit_ptr_nxt = '0;
							led_ptr_nxt = led_ptr_inc;
							if (mode_q == rlsd_pkg::MODE_FRAME) begin
								if (32'(led_ptr_inc) >= 32'(act_cnt)) begin
									go_latch = 1'b1;
								end else begin
									rd_issue = 1'b1;
									rd_addr  = AW'(led_ptr_inc);
								end
							end else if (32'(led_ptr_inc) >= rlsd_pkg::BLANK_COUNT) begin
								go_latch = 1'b1;
							end else begin
								shift_nxt = '0;
							end
						end
					end
				end
				default: status = rlsd_pkg::STAT_OK;
			endcase
		end else if (fill_last && cfg.commit_en) begin
			// fill commit: first entry is the fill color, no read needed
			mode_nxt    = rlsd_pkg::MODE_FRAME;
			led_ptr_nxt = '0;
			bit_ptr_nxt = '0;
			half_nxt    = 1'b0;
			shift_nxt   = fill_color_q;
		end

		// start of a frame or blanking pass
		if (start_frame || start_blank) begin
			led_ptr_nxt = '0;
			bit_ptr_nxt = '0;
			half_nxt    = 1'b0;
			if (start_blank) begin
				mode_nxt  = rlsd_pkg::MODE_BLANK;
				shift_nxt = '0;
			end else if (act_cnt == '0) begin
				go_latch = 1'b1;
			end else begin
				mode_nxt = rlsd_pkg::MODE_FRAME;
				rd_issue = 1'b1;
				rd_addr  = '0;
			end
		end

		// latch period, zero acts as one
		if (go_latch) begin
			mode_nxt      = rlsd_pkg::MODE_LATCH;
			latch_cnt_nxt = (cfg.latch_ticks == '0) ? LW'(1) : cfg.latch_ticks;
		end
	end

	assign res_load = (acc && !fill_go) || fill_last;

	// control and serial state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= rlsd_pkg::CTL_CLEAR;
			mode_q        <= rlsd_pkg::MODE_IDLE;
			led_ptr_q     <= '0;
			bit_ptr_q     <= '0;
			half_q        <= 1'b0;
			shift_q       <= '0;
			latch_cnt_q   <= '0;
			refresh_cnt_q <= '0;
			clk_line_q    <= 1'b0;
			data_line_q   <= 1'b0;
			load_pend_q   <= 1'b0;
			fill_addr_q   <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			st_q          <= st_nxt;
			mode_q        <= mode_nxt;
			led_ptr_q     <= led_ptr_nxt;
			bit_ptr_q     <= bit_ptr_nxt;
			half_q        <= half_nxt;
			shift_q       <= shift_nxt;
			latch_cnt_q   <= latch_cnt_nxt;
			refresh_cnt_q <= refresh_cnt_nxt;
			clk_line_q    <= clk_line_nxt;
			data_line_q   <= data_line_nxt;
			load_pend_q   <= rd_issue;
			if ((st_q != rlsd_pkg::CTL_RUN)) begin
				fill_addr_q <= (clear_last || fill_last) ? '0 : fill_addr_q + AW'(1);
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// fill color and result payload
	always_ff @(posedge clk) begin
		if (fill_go) begin
			fill_color_q <= color_in;
		end
		if (res_load) begin
			res_clk_q    <= clk_line_nxt;
			res_data_q   <= data_line_nxt;
			res_busy_q   <= (mode_nxt != rlsd_pkg::MODE_IDLE);
			res_status_q <= status;
		end
	end

	assign result_out.valid        = res_valid_q;
	assign result_out.serial_clock = res_clk_q;
	assign result_out.serial_data  = res_data_q;
	assign result_out.busy_res     = res_busy_q;
	assign result_out.status       = res_status_q;

endmodule

`default_nettype wire

/* hdl/rgb_led_strip_shift_driver.sv */
// top level: configuration registers, control and frame buffer
//
// channel   | dir | handshake     | carries
// item_in   | in  | valid/ready   | action, led_index, red, green, blue, end_of_batch
// result_out| out | valid/ready   | serial_clock, serial_data, busy_res, status
// cfg_wr    | in  | valid/ready   | reg_index, wr_data (always ready)
//
// ticks, sets, sends and blanks register their result as they are taken; an item is
// taken while the previous result still sits in the output register if that
// result is taken in the same cycle. a fill stalls the input while it writes each
// LED in use through the single buffer write port. after reset a clearing pass
// writes zero to all 1024 buffer entries with no item accepted meanwhile.
// reset is asynchronous; stalls on the result side hold the input off.
`default_nettype none

module rgb_led_strip_shift_driver (
	input  wire logic       clk,
	input  wire logic       arst_n,
	rlsd_item_if.sink       item_in,
	rlsd_result_if.source   result_out,
	rlsd_cfg_if.sink        cfg_wr
);

	rlsd_pkg::cfg_t    cfg_q;
	rlsd_pkg::fb_req_t fb_req;
	logic [rlsd_pkg::COLOR_W-1:0] fb_rdata;

	assign cfg_wr.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_count      <= rlsd_pkg::LED_COUNT_RST;
			cfg_q.commit_en      <= 1'b0;
			cfg_q.refresh_period <= '0;
			cfg_q.latch_ticks    <= rlsd_pkg::LATCH_TICKS_RST;
		end else if (cfg_wr.valid) begin
			unique case (cfg_wr.reg_index)
				rlsd_pkg::REG_LED_COUNT:
					cfg_q.led_count <= cfg_wr.wr_data[rlsd_pkg::COUNT_W-1:0];
				rlsd_pkg::REG_COMMIT_EN:
					cfg_q.commit_en <= cfg_wr.wr_data[0];
				rlsd_pkg::REG_REFRESH_PERIOD:
					cfg_q.refresh_period <= cfg_wr.wr_data[rlsd_pkg::PERIOD_W-1:0];
				rlsd_pkg::REG_LATCH_TICKS:
					cfg_q.latch_ticks <= cfg_wr.wr_data[rlsd_pkg::LATCH_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	rlsd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_in    (item_in),
		.result_out (result_out),
		.fb_req     (fb_req),
		.fb_rdata   (fb_rdata)
	);

	rlsd_frame_mem u_frame_mem (
		.clk   (clk),
		.req   (fb_req),
		.rdata (fb_rdata)
	);

endmodule

`default_nettype wire
